>>> rtl/core/patg_pkg.sv
// ============================================================================
// patg_pkg
// Shared types, widths, register map and reset values for the pad aftertouch
// gesture gate.
// ============================================================================
package patg_pkg;

    localparam int PAD_COUNT_DEFAULT = 16;
    localparam int PAD_IDX_W         = 4;
    localparam int PRESSURE_W        = 7;
    localparam int TIME_W            = 32;
    localparam int COUNT_W           = 4;
    localparam int SPAN_W            = 16;
    localparam int CFG_DATA_W        = 32;
    localparam int CFG_ADDR_W        = 5;
    localparam int QUEUE_DEPTH       = 2;

    typedef enum logic [2:0] {
        REG_GESTURE_CHANGES   = 3'd0,
        REG_GESTURE_WINDOW_MS = 3'd1,
        REG_GESTURE_THRESHOLD = 3'd2,
        REG_SEND_TIMEOUT_MS   = 3'd3,
        REG_SEND_STEP         = 3'd4,
        REG_IGNORE_MS         = 3'd5
    } reg_index_t;

    localparam logic [COUNT_W-1:0]    RST_GESTURE_CHANGES   = 4'd2;
    localparam logic [SPAN_W-1:0]     RST_GESTURE_WINDOW_MS = 16'd500;
    localparam logic [PRESSURE_W-1:0] RST_GESTURE_THRESHOLD = 7'd10;
    localparam logic [SPAN_W-1:0]     RST_SEND_TIMEOUT_MS   = 16'd100;
    localparam logic [PRESSURE_W-1:0] RST_SEND_STEP         = 7'd2;
    localparam logic [SPAN_W-1:0]     RST_IGNORE_MS         = 16'd10;

    typedef struct packed {
        logic [COUNT_W-1:0]    gesture_changes;
        logic [SPAN_W-1:0]     gesture_window_ms;
        logic [PRESSURE_W-1:0] gesture_threshold;
        logic [SPAN_W-1:0]     send_timeout_ms;
        logic [PRESSURE_W-1:0] send_step;
        logic [SPAN_W-1:0]     ignore_ms;
    } cfg_t;

    typedef struct packed {
        logic                  live;
        logic [PAD_IDX_W-1:0]  pad_index;
        logic [PRESSURE_W-1:0] velocity_scaled_pressure;
        logic [PRESSURE_W-1:0] aftertouch_scaled_pressure;
        logic [TIME_W-1:0]     now_ms;
    } queue_entry_t;

    typedef struct packed {
        logic [COUNT_W-1:0]    change_count;
        logic [TIME_W-1:0]     gesture_start_time;
        logic [PRESSURE_W-1:0] reference_pressure;
        logic                  last_direction_down;
        logic [PRESSURE_W-1:0] last_sent_value;
        logic [TIME_W-1:0]     last_send_time;
    } pad_state_t;

    typedef struct packed {
        logic                  gesture_active;
        logic                  send_valid;
        logic [PRESSURE_W-1:0] aftertouch_value;
    } result_t;

endpackage

>>> rtl/core/patg_if.sv
// ============================================================================
// patg_sample_if / patg_result_if
// Valid/ready channels for pad samples in and gate results out.
// ============================================================================
interface patg_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic [patg_pkg::PAD_IDX_W-1:0]       pad_index;
    logic                                 pad_down;
    logic                                 send_allowed;
    logic [patg_pkg::PRESSURE_W-1:0]      velocity_scaled_pressure;
    logic [patg_pkg::PRESSURE_W-1:0]      aftertouch_scaled_pressure;
    logic [patg_pkg::TIME_W-1:0]          now_ms;

    modport source (
        output valid, pad_index, pad_down, send_allowed,
               velocity_scaled_pressure, aftertouch_scaled_pressure, now_ms,
        input  ready
    );
    modport sink (
        input  valid, pad_index, pad_down, send_allowed,
               velocity_scaled_pressure, aftertouch_scaled_pressure, now_ms,
        output ready
    );
endinterface

interface patg_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 gesture_active;
    logic                                 send_valid;
    logic [patg_pkg::PRESSURE_W-1:0]      aftertouch_value;

    modport source (
        output valid, gesture_active, send_valid, aftertouch_value,
        input  ready
    );
    modport sink (
        input  valid, gesture_active, send_valid, aftertouch_value,
        output ready
    );
endinterface

>>> rtl/core/patg_regs.sv
// ============================================================================
// patg_regs
// APB configuration registers: gesture target, window, threshold and the
// send rate limits.
// ============================================================================
module patg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [patg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [patg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [patg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    output patg_pkg::cfg_t                      cfg
);

    patg_pkg::cfg_t       cfg_reg;
    patg_pkg::cfg_t       cfg_next;
    patg_pkg::reg_index_t index;
    logic                 wr_en;

    assign index  = patg_pkg::reg_index_t'(paddr[patg_pkg::CFG_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (index)
                patg_pkg::REG_GESTURE_CHANGES:
                    cfg_next.gesture_changes = pwdata[patg_pkg::COUNT_W-1:0];
                patg_pkg::REG_GESTURE_WINDOW_MS:
                    cfg_next.gesture_window_ms = pwdata[patg_pkg::SPAN_W-1:0];
                patg_pkg::REG_GESTURE_THRESHOLD:
                    cfg_next.gesture_threshold = pwdata[patg_pkg::PRESSURE_W-1:0];
                patg_pkg::REG_SEND_TIMEOUT_MS:
                    cfg_next.send_timeout_ms = pwdata[patg_pkg::SPAN_W-1:0];
                patg_pkg::REG_SEND_STEP:
                    cfg_next.send_step = pwdata[patg_pkg::PRESSURE_W-1:0];
                patg_pkg::REG_IGNORE_MS:
                    cfg_next.ignore_ms = pwdata[patg_pkg::SPAN_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            patg_pkg::REG_GESTURE_CHANGES:
                prdata = patg_pkg::CFG_DATA_W'(cfg_reg.gesture_changes);
            patg_pkg::REG_GESTURE_WINDOW_MS:
                prdata = patg_pkg::CFG_DATA_W'(cfg_reg.gesture_window_ms);
            patg_pkg::REG_GESTURE_THRESHOLD:
                prdata = patg_pkg::CFG_DATA_W'(cfg_reg.gesture_threshold);
            patg_pkg::REG_SEND_TIMEOUT_MS:
                prdata = patg_pkg::CFG_DATA_W'(cfg_reg.send_timeout_ms);
            patg_pkg::REG_SEND_STEP:
                prdata = patg_pkg::CFG_DATA_W'(cfg_reg.send_step);
            patg_pkg::REG_IGNORE_MS:
                prdata = patg_pkg::CFG_DATA_W'(cfg_reg.ignore_ms);
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gesture_changes   <= patg_pkg::RST_GESTURE_CHANGES;
            cfg_reg.gesture_window_ms <= patg_pkg::RST_GESTURE_WINDOW_MS;
            cfg_reg.gesture_threshold <= patg_pkg::RST_GESTURE_THRESHOLD;
            cfg_reg.send_timeout_ms   <= patg_pkg::RST_SEND_TIMEOUT_MS;
            cfg_reg.send_step         <= patg_pkg::RST_SEND_STEP;
            cfg_reg.ignore_ms         <= patg_pkg::RST_IGNORE_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> rtl/core/patg_front.sv
// ============================================================================
// patg_front
// Sample intake: accept a transfer while the queue has room, mark whether
// the sample reaches the detector, and hand it to the queue.
// ============================================================================
module patg_front #(
    parameter int PAD_COUNT = patg_pkg::PAD_COUNT_DEFAULT
) (
    patg_sample_if.sink                 sample,
    input  logic                        q_ready,
    output logic                        push,
    output patg_pkg::queue_entry_t      push_entry
);

    logic pad_in_range;

    assign pad_in_range = {3'b000, sample.pad_index} < 7'(PAD_COUNT);

    assign sample.ready = q_ready;
    assign push         = sample.valid && q_ready;

    always_comb
    begin
        push_entry.live = pad_in_range && sample.pad_down && sample.send_allowed;
        push_entry.pad_index                  = sample.pad_index;
        push_entry.velocity_scaled_pressure   = sample.velocity_scaled_pressure;
        push_entry.aftertouch_scaled_pressure = sample.aftertouch_scaled_pressure;
        push_entry.now_ms                     = sample.now_ms;
    end

endmodule

>>> rtl/core/patg_queue.sv
// ============================================================================
// patg_queue
// Two-entry queue between sample intake and the per-pad update stage.
// ============================================================================
module patg_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  patg_pkg::queue_entry_t      push_entry,
    output logic                        q_ready,
    output logic                        q_valid,
    output patg_pkg::queue_entry_t      head,
    input  logic                        pop
);

    localparam int PTR_W = $clog2(patg_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(patg_pkg::QUEUE_DEPTH + 1);

    patg_pkg::queue_entry_t entries_reg [patg_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       wr_ptr_next;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;

    assign q_ready = count_reg != CNT_W'(patg_pkg::QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign head    = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> rtl/core/patg_back.sv
// ============================================================================
// patg_back
// Per-pad update: read-modify-write of the pad's gesture and send state,
// with the result held in an output register.
// ============================================================================
module patg_back #(
    parameter int PAD_COUNT = patg_pkg::PAD_COUNT_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  patg_pkg::cfg_t              cfg,
    input  logic                        q_valid,
    input  patg_pkg::queue_entry_t      head,
    output logic                        pop,
    patg_result_if.source               result
);

    localparam int STORE_DEPTH = (PAD_COUNT < (1 << patg_pkg::PAD_IDX_W)) ?
                                 PAD_COUNT : (1 << patg_pkg::PAD_IDX_W);
    localparam int SIDX_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    function automatic logic [patg_pkg::PRESSURE_W-1:0] abs_diff(
        input logic [patg_pkg::PRESSURE_W-1:0] a,
        input logic [patg_pkg::PRESSURE_W-1:0] b
    );
        return (a > b) ? a - b : b - a;
    endfunction

    patg_pkg::pad_state_t state_reg [STORE_DEPTH];
    patg_pkg::pad_state_t cur;
    patg_pkg::pad_state_t upd;
    patg_pkg::result_t    res_reg;
    patg_pkg::result_t    res_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [SIDX_W-1:0]    idx;

    logic                           complete;
    logic [patg_pkg::TIME_W-1:0]    gesture_age;
    logic [patg_pkg::TIME_W-1:0]    send_age;
    logic                           window_expired;
    logic [patg_pkg::COUNT_W-1:0]   count_w;
    logic [patg_pkg::PRESSURE_W-1:0] ref_w;
    logic                           moved;
    logic                           dir_down;
    logic                           send;

    assign pop = q_valid && (!out_valid_reg || result.ready);
    assign idx = head.pad_index[SIDX_W-1:0];
    assign cur = state_reg[idx];

    always_comb
    begin
        complete       = cur.change_count == cfg.gesture_changes;
        gesture_age    = head.now_ms - cur.gesture_start_time;
        send_age       = head.now_ms - cur.last_send_time;
        window_expired = (gesture_age > patg_pkg::TIME_W'(cfg.gesture_window_ms)) &&
                         (cur.change_count != '0);

        upd     = cur;
        count_w = window_expired ? '0 : cur.change_count;
        ref_w   = window_expired ? head.velocity_scaled_pressure : cur.reference_pressure;
        if (window_expired)
        begin
            upd.change_count       = '0;
            upd.gesture_start_time = '0;
            upd.reference_pressure = head.velocity_scaled_pressure;
        end

        moved    = abs_diff(head.velocity_scaled_pressure, ref_w) > cfg.gesture_threshold;
        dir_down = ref_w > head.velocity_scaled_pressure;
        if (moved)
        begin
            if (count_w == '0)
            begin
                upd.reference_pressure = head.velocity_scaled_pressure;
                upd.gesture_start_time = head.now_ms;
                upd.change_count       = patg_pkg::COUNT_W'(1);
            end
            else if (dir_down != cur.last_direction_down)
            begin
                upd.change_count       = count_w + patg_pkg::COUNT_W'(1);
                upd.reference_pressure = head.velocity_scaled_pressure;
            end
            upd.last_direction_down = dir_down;
        end

        // Gesture already complete: the detector holds, only the send path runs.
        send = 1'b0;
        if (complete)
        begin
            upd = cur;
            if (send_age > patg_pkg::TIME_W'(cfg.send_timeout_ms))
            begin
                send = abs_diff(head.aftertouch_scaled_pressure, cur.last_sent_value) >
                       cfg.send_step;
            end
            else
            begin
                send = (head.aftertouch_scaled_pressure != cur.last_sent_value) &&
                       (send_age > patg_pkg::TIME_W'(cfg.ignore_ms));
            end
            if (send)
            begin
                upd.last_sent_value = head.aftertouch_scaled_pressure;
                upd.last_send_time  = head.now_ms;
            end
        end

        res_next.gesture_active   = head.live && complete;
        res_next.send_valid       = head.live && send;
        res_next.aftertouch_value = (head.live && send) ?
                                    head.aftertouch_scaled_pressure : '0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                state_reg[i] <= '0;
            end
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop && head.live)
            begin
                state_reg[idx] <= upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.gesture_active   = res_reg.gesture_active;
    assign result.send_valid       = res_reg.send_valid;
    assign result.aftertouch_value = res_reg.aftertouch_value;

endmodule

>>> rtl/core/pad_aftertouch_gesture_gate_unit.sv
// ============================================================================
// pad_aftertouch_gesture_gate_unit
// Per-pad aftertouch gesture detector and rate-limited aftertouch gate.
//
// Usage:
//   sample : one pressure sample per transfer (pad, pressed, send enable,
//            two scaled pressures, millisecond time).
//   result : one transfer per sample (gesture_active, send_valid,
//            aftertouch_value).
//   APB    : six configuration registers at byte addresses 0x00..0x14;
//            write them only while no sample is in flight.
// A sample passes through the queue and the output register before its
// result is valid. Throughput is one sample per cycle while the result
// receiver keeps up, set by the read-modify-write of the pad's state in
// the update stage. A two-entry queue sits between intake and update;
// when the result receiver stalls, the output register holds, the queue
// fills and sample.ready drops once the queue holds two samples.
// Reset clears all pad state and loads the register defaults at once;
// sample.ready is high straight out of reset.
// ============================================================================
module pad_aftertouch_gesture_gate_unit #(
    parameter int PAD_COUNT = patg_pkg::PAD_COUNT_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    patg_sample_if.sink                         sample,
    patg_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [patg_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [patg_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [patg_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    patg_pkg::cfg_t         cfg;
    patg_pkg::queue_entry_t push_entry;
    patg_pkg::queue_entry_t head;
    logic                   push;
    logic                   pop;
    logic                   q_ready;
    logic                   q_valid;

    patg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    patg_front #(
        .PAD_COUNT (PAD_COUNT)
    ) u_front (
        .sample     (sample),
        .q_ready    (q_ready),
        .push       (push),
        .push_entry (push_entry)
    );

    patg_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .q_ready    (q_ready),
        .q_valid    (q_valid),
        .head       (head),
        .pop        (pop)
    );

    patg_back #(
        .PAD_COUNT (PAD_COUNT)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .q_valid (q_valid),
        .head    (head),
        .pop     (pop),
        .result  (result)
    );

    a_send_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.send_valid) |-> result.gesture_active)
        else $error("send without active gesture");

    a_idle_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.send_valid) |-> (result.aftertouch_value == '0))
        else $error("nonzero aftertouch value without send");

    a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
        (!sample.ready && $past(rst_n)) |-> $past(result.valid && !result.ready))
        else $error("intake stalled without an output stall");

endmodule

>>> tb/tb_pad_aftertouch_gesture_gate_unit.sv
// ============================================================================
// tb_pad_aftertouch_gesture_gate_unit
// Self-checking bench for the pad aftertouch gesture gate. A short table of
// hand-picked samples runs first. Some of its rows carry typed-in results,
// and the rest are checked against a per-pad behavioral predictor. Random
// phases follow, each under its own register setting. They drive pressure
// swings so that gestures complete, and they vary time steps, including
// wraps. Both channels idle at random, and one long result stall backs up
// the sample channel.
// ============================================================================
module tb_pad_aftertouch_gesture_gate_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import patg_pkg::*;

    localparam int PADS = PAD_COUNT_DEFAULT;

    typedef struct {
        logic [PAD_IDX_W-1:0]  pad;
        logic                  down;
        logic                  allowed;
        logic [PRESSURE_W-1:0] vel;
        logic [PRESSURE_W-1:0] aft;
        logic [TIME_W-1:0]     now;
        bit                    fixed;
        result_t               want;
    } pad_sample_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    patg_sample_if pad_in ();
    patg_result_if gate_out ();

    cfg_t                  gate_cfg;
    logic [COUNT_W-1:0]    swing_count    [PADS];
    logic [TIME_W-1:0]     swing_start_ms [PADS];
    logic [PRESSURE_W-1:0] ref_level      [PADS];
    logic                  falling        [PADS];
    logic [PRESSURE_W-1:0] sent_level     [PADS];
    logic [TIME_W-1:0]     sent_ms        [PADS];

    result_t pending_results[$];
    int      errors = 0;
    int      idle_max = 4;

    pad_aftertouch_gesture_gate_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .sample  (pad_in),
        .result  (gate_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    initial
    begin
        pad_in.valid = 1'b0;
        pad_in.pad_index = '0;
        pad_in.pad_down = 1'b0;
        pad_in.send_allowed = 1'b0;
        pad_in.velocity_scaled_pressure = '0;
        pad_in.aftertouch_scaled_pressure = '0;
        pad_in.now_ms = '0;
        gate_out.ready = 1'b0;
    end

    function automatic int level_gap(input logic [PRESSURE_W-1:0] a,
                                     input logic [PRESSURE_W-1:0] b);
        return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
    endfunction

    function automatic result_t gate_predict(input pad_sample_t s);
        result_t           r;
        int                p;
        logic [TIME_W-1:0] dt;
        logic              dir;
        bit                send;
        r = '0;
        p = int'(s.pad);
        send = 1'b0;
        if (!s.down || !s.allowed)
            return r;
        if (swing_count[p] != gate_cfg.gesture_changes)
        begin
            dt = s.now - swing_start_ms[p];
            if (dt > TIME_W'(gate_cfg.gesture_window_ms) && swing_count[p] != 0)
            begin
                swing_count[p] = '0;
                swing_start_ms[p] = '0;
                ref_level[p] = s.vel;
            end
            if (level_gap(s.vel, ref_level[p]) > int'(gate_cfg.gesture_threshold))
            begin
                dir = ref_level[p] > s.vel;
                if (swing_count[p] == 0)
                begin
                    ref_level[p] = s.vel;
                    swing_start_ms[p] = s.now;
                    swing_count[p] = 4'd1;
                end
                else if (dir != falling[p])
                begin
                    swing_count[p] = swing_count[p] + 4'd1;
                    ref_level[p] = s.vel;
                end
                falling[p] = dir;
            end
            return r;
        end
        dt = s.now - sent_ms[p];
        if (dt > TIME_W'(gate_cfg.send_timeout_ms))
            send = level_gap(s.aft, sent_level[p]) > int'(gate_cfg.send_step);
        else
            send = (s.aft != sent_level[p]) && (dt > TIME_W'(gate_cfg.ignore_ms));
        if (send)
        begin
            sent_level[p] = s.aft;
            sent_ms[p] = s.now;
        end
        r.gesture_active = 1'b1;
        r.send_valid = send;
        r.aftertouch_value = send ? s.aft : '0;
        return r;
    endfunction

    function automatic pad_sample_t pad_row(input int pad, input bit down, input bit allowed,
                                            input int vel, input int aft,
                                            input logic [TIME_W-1:0] now,
                                            input bit fixed = 1'b0,
                                            input result_t want = '0);
        pad_sample_t s;
        s.pad = PAD_IDX_W'(pad);
        s.down = down;
        s.allowed = allowed;
        s.vel = PRESSURE_W'(vel);
        s.aft = PRESSURE_W'(aft);
        s.now = now;
        s.fixed = fixed;
        s.want = want;
        return s;
    endfunction

    task automatic offer_sample(input pad_sample_t s);
        int      gap;
        result_t predicted;
        gap = $urandom_range(0, idle_max);
        if (gap > 0)
        begin
            pad_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pad_in.valid <= 1'b1;
        pad_in.pad_index <= s.pad;
        pad_in.pad_down <= s.down;
        pad_in.send_allowed <= s.allowed;
        pad_in.velocity_scaled_pressure <= s.vel;
        pad_in.aftertouch_scaled_pressure <= s.aft;
        pad_in.now_ms <= s.now;
        do @(posedge clk); while (pad_in.ready !== 1'b1);
        predicted = gate_predict(s);
        pending_results.push_back(s.fixed ? s.want : predicted);
    endtask

    task automatic settle();
        pad_in.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        case (idx)
            REG_GESTURE_CHANGES:   gate_cfg.gesture_changes = val[COUNT_W-1:0];
            REG_GESTURE_WINDOW_MS: gate_cfg.gesture_window_ms = val[SPAN_W-1:0];
            REG_GESTURE_THRESHOLD: gate_cfg.gesture_threshold = val[PRESSURE_W-1:0];
            REG_SEND_TIMEOUT_MS:   gate_cfg.send_timeout_ms = val[SPAN_W-1:0];
            REG_SEND_STEP:         gate_cfg.send_step = val[PRESSURE_W-1:0];
            REG_IGNORE_MS:         gate_cfg.ignore_ms = val[SPAN_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_cfg(input cfg_t c);
        write_reg(REG_GESTURE_CHANGES, CFG_DATA_W'(c.gesture_changes));
        write_reg(REG_GESTURE_WINDOW_MS, CFG_DATA_W'(c.gesture_window_ms));
        write_reg(REG_GESTURE_THRESHOLD, CFG_DATA_W'(c.gesture_threshold));
        write_reg(REG_SEND_TIMEOUT_MS, CFG_DATA_W'(c.send_timeout_ms));
        write_reg(REG_SEND_STEP, CFG_DATA_W'(c.send_step));
        write_reg(REG_IGNORE_MS, CFG_DATA_W'(c.ignore_ms));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : result_sink
        int      gap;
        int      seen;
        result_t want;
        seen = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            // hold off long once so the sample channel backs up
            gap = (seen == 200) ? 60 : $urandom_range(0, idle_max);
            if (gap > 0)
            begin
                gate_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            gate_out.ready <= 1'b1;
            do @(posedge clk); while (gate_out.valid !== 1'b1);
            seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no sample pending");
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (gate_out.gesture_active !== want.gesture_active)
                begin
                    $error("gesture_active: expected %0d, got %0d",
                           want.gesture_active, gate_out.gesture_active);
                    errors++;
                end
                if (gate_out.send_valid !== want.send_valid)
                begin
                    $error("send_valid: expected %0d, got %0d",
                           want.send_valid, gate_out.send_valid);
                    errors++;
                end
                if (gate_out.aftertouch_value !== want.aftertouch_value)
                begin
                    $error("aftertouch_value: expected %0d, got %0d",
                           want.aftertouch_value, gate_out.aftertouch_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin : stimulus
        pad_sample_t           rows[$];
        pad_sample_t           s;
        cfg_t                  c;
        logic [TIME_W-1:0]     clock_ms;
        bit                    swing_hi [PADS];
        logic [PRESSURE_W-1:0] aft_last [PADS];
        int                    p;
        gate_cfg.gesture_changes = RST_GESTURE_CHANGES;
        gate_cfg.gesture_window_ms = RST_GESTURE_WINDOW_MS;
        gate_cfg.gesture_threshold = RST_GESTURE_THRESHOLD;
        gate_cfg.send_timeout_ms = RST_SEND_TIMEOUT_MS;
        gate_cfg.send_step = RST_SEND_STEP;
        gate_cfg.ignore_ms = RST_IGNORE_MS;
        for (int i = 0; i < PADS; i++)
        begin
            swing_count[i] = '0;
            swing_start_ms[i] = '0;
            ref_level[i] = '0;
            falling[i] = 1'b0;
            sent_level[i] = '0;
            sent_ms[i] = '0;
            swing_hi[i] = 1'b0;
            aft_last[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        rows.push_back(pad_row(0, 0, 1, 127, 127, 32'hFFFF_FFFF, 1, '0));
        rows.push_back(pad_row(15, 1, 0, 127, 127, 32'h0, 1, '0));
        rows.push_back(pad_row(1, 1, 1, 0, 0, 32'd0, 1, '0));
        rows.push_back(pad_row(1, 1, 1, 127, 0, 32'd10, 1, '0));
        // completion step still reports inactive
        rows.push_back(pad_row(1, 1, 1, 0, 0, 32'd20, 1, '0));
        rows.push_back(pad_row(1, 1, 1, 0, 127, 32'd200, 1, '{1'b1, 1'b1, 7'd127}));
        rows.push_back(pad_row(1, 1, 1, 64, 0, 32'd205));
        rows.push_back(pad_row(1, 1, 1, 64, 0, 32'd216));
        rows.push_back(pad_row(1, 1, 1, 64, 1, 32'd300));
        rows.push_back(pad_row(1, 1, 1, 64, 3, 32'd401));
        rows.push_back(pad_row(1, 1, 0, 64, 90, 32'd900, 1, '0));
        rows.push_back(pad_row(2, 1, 1, 100, 0, 32'hFFFF_FFF0));
        rows.push_back(pad_row(2, 1, 1, 20, 0, 32'h0000_0005));
        rows.push_back(pad_row(2, 1, 1, 20, 127, 32'h0000_0010));
        rows.push_back(pad_row(3, 1, 1, 50, 0, 32'd1000));
        rows.push_back(pad_row(3, 1, 1, 0, 0, 32'd1600));
        rows.push_back(pad_row(3, 1, 1, 11, 0, 32'd1601));
        rows.push_back(pad_row(3, 1, 1, 0, 0, 32'd1602));
        rows.push_back(pad_row(3, 1, 1, 127, 127, 32'd1603));
        rows.push_back(pad_row(4, 1, 1, 60, 0, 32'd2000));
        rows.push_back(pad_row(4, 1, 1, 80, 0, 32'd2001));
        rows.push_back(pad_row(4, 1, 1, 40, 0, 32'd2002));
        rows.push_back(pad_row(15, 1, 1, 127, 127, 32'hFFFF_FFFF));
        foreach (rows[i])
            offer_sample(rows[i]);

        for (int ph = 0; ph < 6; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    c.gesture_changes = 4'd1;
                    c.gesture_window_ms = 16'hFFFF;
                    c.gesture_threshold = 7'd0;
                    c.send_timeout_ms = 16'd0;
                    c.send_step = 7'd0;
                    c.ignore_ms = 16'd0;
                end
                1:
                begin
                    c.gesture_changes = 4'd15;
                    c.gesture_window_ms = 16'd0;
                    c.gesture_threshold = 7'd127;
                    c.send_timeout_ms = 16'hFFFF;
                    c.send_step = 7'd127;
                    c.ignore_ms = 16'hFFFF;
                end
                2:
                begin
                    // zero target: idle pads count as complete
                    c.gesture_changes = 4'd0;
                    c.gesture_window_ms = 16'd500;
                    c.gesture_threshold = 7'd10;
                    c.send_timeout_ms = 16'd100;
                    c.send_step = 7'd2;
                    c.ignore_ms = 16'd10;
                end
                default:
                begin
                    c.gesture_changes = ($urandom_range(0, 3) == 0) ?
                        COUNT_W'($urandom_range(1, 15)) : COUNT_W'($urandom_range(1, 3));
                    c.gesture_window_ms = SPAN_W'($urandom_range(20, 1500));
                    c.gesture_threshold = PRESSURE_W'($urandom_range(0, 40));
                    c.send_timeout_ms = SPAN_W'($urandom_range(0, 300));
                    c.send_step = PRESSURE_W'($urandom_range(0, 12));
                    c.ignore_ms = SPAN_W'($urandom_range(0, 60));
                end
            endcase
            program_cfg(c);
            idle_max = (ph % 3 == 1) ? 0 : 4;
            clock_ms = $urandom;
            repeat (100)
            begin
                p = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(0, 15);
                s.pad = PAD_IDX_W'(p);
                s.down = ($urandom_range(0, 9) != 0);
                s.allowed = ($urandom_range(0, 9) != 0);
                case ($urandom_range(0, 19))
                    0: clock_ms += $urandom_range(0, 3000);
                    1: clock_ms = $urandom;
                    default: clock_ms += $urandom_range(0, 25);
                endcase
                s.now = clock_ms;
                if ($urandom_range(0, 4) == 0)
                    s.vel = PRESSURE_W'($urandom_range(0, 127));
                else
                begin
                    swing_hi[p] = ~swing_hi[p];
                    s.vel = swing_hi[p] ? PRESSURE_W'($urandom_range(80, 127)) :
                                          PRESSURE_W'($urandom_range(0, 47));
                end
                if ($urandom_range(0, 1) == 0)
                    s.aft = PRESSURE_W'($urandom_range(0, 127));
                else
                    s.aft = aft_last[p] + PRESSURE_W'($urandom_range(0, 6)) - 7'd3;
                aft_last[p] = s.aft;
                s.fixed = 1'b0;
                s.want = '0;
                offer_sample(s);
            end
        end
        settle();

        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin : watchdog
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
